// File: rtl/pthc_pkg.sv
package pthc_pkg;

	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned PIPE_LAST = 87;

	localparam logic [63:0] PRESS_TEMP_OFS = 64'd128000;
	localparam logic [20:0] PRESS_RAW_BASE = 21'd1048576;
	localparam logic [63:0] PRESS_SCALE = 64'd3125;
	localparam logic [63:0] PRESS_BIAS = 64'd1 << 47;
	localparam logic [31:0] HUM_TEMP_OFS = 32'd76800;
	localparam logic [31:0] HUM_ROUND_A = 32'd16384;
	localparam logic [31:0] HUM_OFS_B = 32'd32768;
	localparam logic [31:0] HUM_OFS_C = 32'd2097152;
	localparam logic [31:0] HUM_ROUND_D = 32'd8192;
	localparam logic [31:0] HUM_LIMIT = 32'd419430400;
	localparam logic [24:0] PRESS_FIELD_MAX = 25'h1FFFFFF;

	typedef enum logic [2:0] {
		CFG_TEMP       = 3'd0,
		CFG_PRESS_LOW  = 3'd1,
		CFG_PRESS_HIGH = 3'd2,
		CFG_PRESS_NINE = 3'd3,
		CFG_HUM        = 3'd4,
		CFG_PRESS_MIN  = 3'd5,
		CFG_PRESS_MAX  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] tf;
		logic [23:0] tc;
		logic [16:0] hum;
		logic        dz;
	} side_t;

	typedef struct packed {
		logic [31:0] tf;
		logic [23:0] tc;
		logic [24:0] press;
		logic        pvalid;
		logic [16:0] hum;
	} res_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sar64(input logic [63:0] x, input int unsigned s);
		logic signed [63:0] xs;
		xs = x;
		return xs >>> s;
	endfunction

	function automatic logic [31:0] sar32(input logic [31:0] x, input int unsigned s);
		logic signed [31:0] xs;
		xs = x;
		return xs >>> s;
	endfunction

endpackage

// File: rtl/pth_sensor_compensation.sv
// Pressure, temperature and humidity compensation for one raw sample set.
//
// A raw sample set enters on the sample channel (raw_temperature,
// raw_pressure, raw_humidity) and one compensated result leaves on the
// result channel: fine temperature, temperature in hundredths of a degree,
// pressure in Pa as Q17.8 with a validity flag, and humidity as Q7.10.
// Calibration coefficients and the pressure window are written through the
// cfg channel, which is always ready; write it only while no item is in
// flight.
//
// One item is taken every cycle unless the pipeline is held by the output
// queue; the depth comes from the 64-stage signed divider of the pressure
// formula plus the 64-bit multiplier stages around it.
//
// Reset clears the coefficients, sets the pressure window to the full range
// and empties the pipeline. A two-entry output queue keeps accepting while
// one result waits; once both entries are full and result_ready is low the
// whole pipeline holds and sample_ready drops.
module pth_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	input  logic [15:0] raw_humidity,
	output logic        result_valid,
	input  logic        result_ready,
	output logic signed [31:0] fine_temperature,
	output logic signed [23:0] temperature_centi,
	output logic [24:0] pressure_fixed,
	output logic        pressure_valid,
	output logic [16:0] humidity_fixed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import pthc_pkg::*;

	logic [47:0] temp_q;
	logic [63:0] plo_q;
	logic [63:0] phi_q;
	logic [15:0] p9_q;
	logic [63:0] hum_q;
	logic [24:0] pmin_q;
	logic [24:0] pmax_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			plo_q  <= '0;
			phi_q  <= '0;
			p9_q   <= '0;
			hum_q  <= '0;
			pmin_q <= '0;
			pmax_q <= PRESS_FIELD_MAX;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TEMP:       temp_q <= cfg_data[47:0];
				CFG_PRESS_LOW:  plo_q  <= cfg_data;
				CFG_PRESS_HIGH: phi_q  <= cfg_data;
				CFG_PRESS_NINE: p9_q   <= cfg_data[15:0];
				CFG_HUM:        hum_q  <= cfg_data;
				CFG_PRESS_MIN:  pmin_q <= cfg_data[24:0];
				CFG_PRESS_MAX:  pmax_q <= cfg_data[24:0];
				default: begin
				end
			endcase
		end
	end

	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign p1 = {48'd0, plo_q[15:0]};
	assign p2 = sx16(plo_q[31:16]);
	assign p3 = sx16(plo_q[47:32]);
	assign p4 = sx16(plo_q[63:48]);
	assign p5 = sx16(phi_q[15:0]);
	assign p6 = sx16(phi_q[31:16]);
	assign p7 = sx16(phi_q[47:32]);
	assign p8 = sx16(phi_q[63:48]);
	assign p9 = sx16(p9_q);

	// Flow control and output queue.
	logic             adv;
	logic [PIPE_LAST:1] pipe_valid_q;
	res_t             fifo_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push, pop;
	res_t             res_new;

	assign adv          = !(cnt_q == 2'd2 && !result_ready);
	assign sample_ready = adv;
	assign push         = adv && pipe_valid_q[PIPE_LAST];
	assign pop          = result_valid && result_ready;
	assign result_valid = cnt_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_valid_q <= '0;
			wr_ptr_q     <= 1'b0;
			rd_ptr_q     <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (adv) begin
				pipe_valid_q <= {pipe_valid_q[PIPE_LAST-1:1], sample_valid};
			end
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_new;
		end
	end

	assign fine_temperature  = fifo_q[rd_ptr_q].tf;
	assign temperature_centi = fifo_q[rd_ptr_q].tc;
	assign pressure_fixed    = fifo_q[rd_ptr_q].press;
	assign pressure_valid    = fifo_q[rd_ptr_q].pvalid;
	assign humidity_fixed    = fifo_q[rd_ptr_q].hum;

	// Temperature.
	logic [15:0] t1, t2, t3;
	assign t1 = temp_q[15:0];
	assign t2 = temp_q[31:16];
	assign t3 = temp_q[47:32];

	logic [17:0] ta_s1, d_s1;
	logic [20:0] pn_s [1:10];
	logic [15:0] rh_s [1:5];
	logic [31:0] a1p_s2, dd_s2;
	logic [31:0] a1_s3, t3p_s3;
	logic [31:0] tf_s [4:15];
	logic [23:0] tc_s [5:15];
	logic [63:0] v1p_s5;
	logic [31:0] hv_s5;

	logic signed [35:0] tf_x, tc_full, tc_sh;
	assign tf_x    = {{4{tf_s[4][31]}}, tf_s[4]};
	assign tc_full = (tf_x <<< 2) + tf_x + 36'sd128;
	assign tc_sh   = tc_full >>> 8;

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s1   <= {1'b0, raw_temperature[19:3]} - {1'b0, t1, 1'b0};
			d_s1    <= {2'd0, raw_temperature[19:4]} - {2'd0, t1};
			pn_s[1] <= PRESS_RAW_BASE - {1'b0, raw_pressure};
			rh_s[1] <= raw_humidity;
			for (int k = 2; k <= 10; k++) begin
				pn_s[k] <= pn_s[k-1];
			end
			for (int k = 2; k <= 5; k++) begin
				rh_s[k] <= rh_s[k-1];
			end
			a1p_s2  <= {{14{ta_s1[17]}}, ta_s1} * {{16{t2[15]}}, t2};
			dd_s2   <= {{14{d_s1[17]}}, d_s1} * {{14{d_s1[17]}}, d_s1};
			a1_s3   <= sar32(a1p_s2, 11);
			t3p_s3  <= sar32(dd_s2, 12) * {{16{t3[15]}}, t3};
			tf_s[4] <= a1_s3 + sar32(t3p_s3, 14);
			for (int k = 5; k <= 15; k++) begin
				tf_s[k] <= tf_s[k-1];
			end
			if (tc_sh < -36'sd8388608) begin
				tc_s[5] <= 24'h800000;
			end else if (tc_sh > 36'sd8388607) begin
				tc_s[5] <= 24'h7FFFFF;
			end else begin
				tc_s[5] <= tc_sh[23:0];
			end
			for (int k = 6; k <= 15; k++) begin
				tc_s[k] <= tc_s[k-1];
			end
			v1p_s5 <= {{32{tf_s[4][31]}}, tf_s[4]} - PRESS_TEMP_OFS;
			hv_s5  <= tf_s[4] - HUM_TEMP_OFS;
		end
	end

	logic [16:0] hum_s15;
	pthc_hum u_hum (
		.clk    (clk),
		.en     (adv),
		.coeffs (hum_q),
		.hv     (hv_s5),
		.rh     (rh_s[5]),
		.hum    (hum_s15)
	);

	// Pressure, ahead of the divider.
	logic [63:0] a_s7, b_s7, c_s7, a6_s9, a3_s9;
	logic [63:0] b_s8, b_s9, c_s8, c_s9;
	logic [63:0] v2_s10, v1c_s10, nm_s11, d_s12, n_s13, n_s14, n_s15;
	logic [30:0] dv_s13, dv_s14, dv_s15;

	pthc_mul64 u_mul_a  (.clk(clk), .en(adv), .a(v1p_s5), .b(v1p_s5), .p(a_s7));
	pthc_mul64 u_mul_b  (.clk(clk), .en(adv), .a(v1p_s5), .b(p5), .p(b_s7));
	pthc_mul64 u_mul_c  (.clk(clk), .en(adv), .a(v1p_s5), .b(p2), .p(c_s7));
	pthc_mul64 u_mul_a6 (.clk(clk), .en(adv), .a(a_s7), .b(p6), .p(a6_s9));
	pthc_mul64 u_mul_a3 (.clk(clk), .en(adv), .a(a_s7), .b(p3), .p(a3_s9));
	pthc_mul64 u_mul_d  (.clk(clk), .en(adv), .a(v1c_s10), .b(p1), .p(d_s12));
	pthc_mul64 u_mul_n  (.clk(clk), .en(adv), .a(nm_s11), .b(PRESS_SCALE), .p(n_s13));

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s8    <= b_s7;
			b_s9    <= b_s8;
			c_s8    <= c_s7;
			c_s9    <= c_s8;
			v2_s10  <= a6_s9 + (b_s9 << 17) + (p4 << 35);
			v1c_s10 <= sar64(a3_s9, 8) + (c_s9 << 12) + PRESS_BIAS;
			nm_s11  <= {12'd0, pn_s[10], 31'd0} - v2_s10;
			// The divisor is the product shifted down by 33, so its top 31 bits.
			dv_s13  <= d_s12[63:33];
			dv_s14  <= dv_s13;
			dv_s15  <= dv_s14;
			n_s14   <= n_s13;
			n_s15   <= n_s14;
		end
	end

	side_t side_s15, side_s81;
	logic [63:0] quot_s81;
	assign side_s15 = '{tf: tf_s[15], tc: tc_s[15], hum: hum_s15, dz: dv_s15 == 31'd0};

	pthc_sdiv u_sdiv (
		.clk      (clk),
		.en       (adv),
		.num      (n_s15),
		.den      (dv_s15),
		.side_in  (side_s15),
		.quot     (quot_s81),
		.side_out (side_s81)
	);

	// Pressure, after the divider.
	logic [63:0] q81, qq_s83, r8_s83, r9_s85, r8_s84, r8_s85;
	logic [63:0] pq_s [82:85];
	side_t       side_s [82:87];
	logic [63:0] sum_s86, pf_s87;
	assign q81 = sar64(quot_s81, 13);

	pthc_mul64 u_mul_qq (.clk(clk), .en(adv), .a(q81), .b(q81), .p(qq_s83));
	pthc_mul64 u_mul_r8 (.clk(clk), .en(adv), .a(quot_s81), .b(p8), .p(r8_s83));
	pthc_mul64 u_mul_r9 (.clk(clk), .en(adv), .a(qq_s83), .b(p9), .p(r9_s85));

	always_ff @(posedge clk) begin
		if (adv) begin
			pq_s[82]   <= quot_s81;
			side_s[82] <= side_s81;
			for (int k = 83; k <= 85; k++) begin
				pq_s[k] <= pq_s[k-1];
			end
			for (int k = 83; k <= 87; k++) begin
				side_s[k] <= side_s[k-1];
			end
			r8_s84  <= r8_s83;
			r8_s85  <= r8_s84;
			sum_s86 <= pq_s[85] + sar64(r9_s85, 25) + sar64(r8_s85, 19);
			pf_s87  <= sar64(sum_s86, 8) + (p7 << 4);
		end
	end

	logic pf_neg, pf_big, pf_in_win;
	assign pf_neg    = pf_s87[63];
	assign pf_big    = !pf_neg && (|pf_s87[62:25]);
	assign pf_in_win = !pf_neg && !pf_big && (pf_s87[24:0] >= pmin_q)
		&& (pf_s87[24:0] <= pmax_q);

	always_comb begin
		res_new.tf     = side_s[87].tf;
		res_new.tc     = side_s[87].tc;
		res_new.hum    = side_s[87].hum;
		res_new.pvalid = !side_s[87].dz && pf_in_win;
		if (side_s[87].dz || pf_neg) begin
			res_new.press = '0;
		end else if (pf_big) begin
			res_new.press = PRESS_FIELD_MAX;
		end else begin
			res_new.press = pf_s87[24:0];
		end
	end

	a_stall_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (cnt_q == 2'd2) && !result_ready)
		else $error("pipeline held without a full output queue");

	a_last_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_valid_q[PIPE_LAST] && !sample_ready |=> pipe_valid_q[PIPE_LAST])
		else $error("finished item dropped during a stall");

	a_enter_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> pipe_valid_q[1])
		else $error("accepted item did not enter the pipeline");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !result_ready |-> !push)
		else $error("item pushed into a full output queue");

endmodule

// File: rtl/pthc_mul64.sv
module pthc_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;

	// Only the low 64 bits of the product are kept, so the high-by-high
	// partial product never contributes.
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[31:0] * b[31:0];
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
			p     <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
		end
	end
endmodule

// File: rtl/pthc_sdiv.sv
module pthc_sdiv (
	input  logic            clk,
	input  logic            en,
	input  logic [63:0]     num,
	input  logic [30:0]     den,
	input  pthc_pkg::side_t side_in,
	output logic [63:0]     quot,
	output pthc_pkg::side_t side_out
);
	import pthc_pkg::*;

	logic [30:0] rem_s  [0:DIV_STEPS];
	logic [63:0] dq_s   [0:DIV_STEPS];
	logic [30:0] dm_s   [0:DIV_STEPS];
	logic        neg_s  [0:DIV_STEPS];
	side_t       side_s [0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			dq_s[0]   <= num[63] ? 64'd0 - num : num;
			dm_s[0]   <= den[30] ? 31'd0 - den : den;
			neg_s[0]  <= num[63] ^ den[30];
			side_s[0] <= side_in;
		end
	end

	// One quotient bit per stage; the remainder stays below the divisor,
	// which never exceeds 2^30.
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [31:0] trial;
		logic        ge;
		assign trial = {rem_s[k-1], dq_s[k-1][63]};
		assign ge    = trial >= {1'b0, dm_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? 31'(trial - {1'b0, dm_s[k-1]}) : trial[30:0];
				dq_s[k]   <= {dq_s[k-1][62:0], ge};
				dm_s[k]   <= dm_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot     <= neg_s[DIV_STEPS] ? 64'd0 - dq_s[DIV_STEPS] : dq_s[DIV_STEPS];
			side_out <= side_s[DIV_STEPS];
		end
	end
endmodule

// File: rtl/pthc_hum.sv
module pthc_hum (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] coeffs,
	input  logic [31:0] hv,
	input  logic [15:0] rh,
	output logic [16:0] hum
);
	import pthc_pkg::*;

	logic [7:0]  h1;
	logic [15:0] h2;
	logic [7:0]  h3;
	logic [11:0] h4;
	logic [11:0] h5;
	logic [7:0]  h6;
	assign h1 = coeffs[7:0];
	assign h2 = coeffs[23:8];
	assign h3 = coeffs[31:24];
	assign h4 = coeffs[43:32];
	assign h5 = coeffs[55:44];
	assign h6 = coeffs[63:56];

	logic [31:0] m5_s6, m6_s6, m3_s6;
	logic [15:0] rh_s6;
	logic [31:0] x1_s7, ha_s7, hb_s7;
	logic [31:0] x1_s8, hab_s8;
	logic [31:0] x1_s9, hc_s9;
	logic [31:0] x1_s10, hc2_s10;
	logic [31:0] x1_s11, x2_s11;
	logic [31:0] vv_s12;
	logic [31:0] vv_s13, sq_s13;
	logic [31:0] vv_s14, t_s14;
	logic [31:0] s12;
	logic [31:0] v15;

	assign s12 = sar32(vv_s12, 15);
	assign v15 = vv_s14 - sar32(t_s14, 4);

	always_ff @(posedge clk) begin
		if (en) begin
			m5_s6   <= {{20{h5[11]}}, h5} * hv;
			m6_s6   <= hv * {{24{h6[7]}}, h6};
			m3_s6   <= hv * {24'd0, h3};
			rh_s6   <= rh;
			x1_s7   <= sar32({2'd0, rh_s6, 14'd0} - {h4, 20'd0} - m5_s6 + HUM_ROUND_A, 15);
			ha_s7   <= sar32(m6_s6, 10);
			hb_s7   <= sar32(m3_s6, 11) + HUM_OFS_B;
			hab_s8  <= ha_s7 * hb_s7;
			x1_s8   <= x1_s7;
			hc_s9   <= sar32(hab_s8, 10) + HUM_OFS_C;
			x1_s9   <= x1_s8;
			hc2_s10 <= hc_s9 * {{16{h2[15]}}, h2};
			x1_s10  <= x1_s9;
			x2_s11  <= sar32(hc2_s10 + HUM_ROUND_D, 14);
			x1_s11  <= x1_s10;
			vv_s12  <= x1_s11 * x2_s11;
			sq_s13  <= s12 * s12;
			vv_s13  <= vv_s12;
			t_s14   <= sar32(sq_s13, 7) * {24'd0, h1};
			vv_s14  <= vv_s13;
			// A negative result clamps to zero, anything above 100 %RH to the limit.
			if (v15[31]) begin
				hum <= '0;
			end else if (v15 > HUM_LIMIT) begin
				hum <= HUM_LIMIT[28:12];
			end else begin
				hum <= v15[28:12];
			end
		end
	end
endmodule
